[src/lir_pkg.sv]
`timescale 1ns / 1ps

package lir_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_STEP_RATIO    = 2'd0;
  localparam logic [1:0] REG_CHANNEL_COUNT = 2'd1;

  typedef struct packed {
    logic signed [31:0] sample;
    logic               start_of_stream;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] out_sample;
    logic [2:0]         out_channel;
  } out_word_t;

  // Issue of one word from the control stage to the interpolation pipeline
  typedef struct packed {
    logic fire;        // word produces an output
    logic bypass;      // frame 0: output is the sample itself
    logic prev_valid;  // stored previous sample was ever written
  } lir_issue_t;

endpackage

[src/lir_ram.sv]
`timescale 1ns / 1ps

module lir_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read-first: a read and a write of the same entry in one cycle return the old data.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

[src/lir_ctrl.sv]
`timescale 1ns / 1ps

module lir_ctrl
  import lir_pkg::*;
#(
  parameter int CHANNEL_SLOTS = 8,
  parameter int FRACTION_BITS = 24,
  localparam int CH_W  = (CHANNEL_SLOTS > 1) ? $clog2(CHANNEL_SLOTS) : 1,
  localparam int CW    = $clog2(CHANNEL_SLOTS + 1),
  localparam int INT_W = 32 - FRACTION_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  in_word_t                 in_data,
  input  logic                     ready,
  input  logic [31:0]              step_ratio,
  input  logic [3:0]               channel_count,
  output logic                     accept,
  output lir_issue_t               issue,
  output logic [FRACTION_BITS-1:0] issue_frac,
  output logic [CH_W-1:0]          issue_chan,
  output logic [31:0]              issue_sample
);

  localparam logic [32:0] ONE = 33'(1) << FRACTION_BITS;

  logic [FRACTION_BITS-1:0] phase_fraction, phase_fraction_next;
  logic [INT_W-1:0]         frames_to_wait, frames_to_wait_next;
  logic [CH_W-1:0]          channel_position, channel_position_next;
  logic                     have_previous, have_previous_next;
  logic [CHANNEL_SLOTS-1:0] prev_valid;

  logic [FRACTION_BITS-1:0] phase_c;
  logic [INT_W-1:0]         wait_c;
  logic [CH_W-1:0]          pos_c;
  logic                     hp_c;
  logic [CW-1:0]            cc;
  logic [CH_W-1:0]          ch;
  logic                     last;
  logic                     due;
  logic [32:0]              step_eff;
  logic [32:0]              pos_sum;
  logic [INT_W:0]           pos_int;

  assign accept = in_valid && ready;

  always_comb begin
    if (channel_count == 4'd0) begin
      cc = CW'(1);
    end else if (5'(channel_count) > 5'(CHANNEL_SLOTS)) begin
      cc = CW'(CHANNEL_SLOTS);
    end else begin
      cc = CW'(channel_count);
    end

    step_eff = (33'(step_ratio) < ONE) ? ONE : 33'(step_ratio);

    // start of stream clears the phase before the word is handled
    if (in_data.start_of_stream) begin
      phase_c = '0;
      wait_c  = '0;
      pos_c   = '0;
      hp_c    = 1'b0;
    end else begin
      phase_c = phase_fraction;
      wait_c  = frames_to_wait;
      pos_c   = channel_position;
      hp_c    = have_previous;
    end

    // drop a partial frame when the count was lowered under the position
    ch   = (CW'(pos_c) >= cc) ? '0 : pos_c;
    last = (CW'(ch) + CW'(1)) == cc;
    due  = !hp_c || (wait_c == '0);

    pos_sum = 33'(phase_c) + step_eff;
    pos_int = pos_sum[32:FRACTION_BITS];

    phase_fraction_next   = phase_c;
    frames_to_wait_next   = wait_c;
    have_previous_next    = hp_c;
    channel_position_next = last ? '0 : ch + CH_W'(1);
    if (last) begin
      if (!hp_c) begin
        have_previous_next  = 1'b1;
        phase_fraction_next = step_eff[FRACTION_BITS-1:0];
        frames_to_wait_next = step_eff[31:FRACTION_BITS];
      end else if (due) begin
        phase_fraction_next = pos_sum[FRACTION_BITS-1:0];
        frames_to_wait_next = INT_W'(pos_int - (INT_W + 1)'(1));
      end else begin
        frames_to_wait_next = wait_c - INT_W'(1);
      end
    end

    issue.fire       = accept && due;
    issue.bypass     = accept && !hp_c;
    issue.prev_valid = prev_valid[ch];
    issue_frac       = phase_c;
    issue_chan       = ch;
    issue_sample     = in_data.sample;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_fraction   <= '0;
      frames_to_wait   <= '0;
      channel_position <= '0;
      have_previous    <= 1'b0;
      prev_valid       <= '0;
    end else if (accept) begin
      phase_fraction   <= phase_fraction_next;
      frames_to_wait   <= frames_to_wait_next;
      channel_position <= channel_position_next;
      have_previous    <= have_previous_next;
      prev_valid[ch]   <= 1'b1;
    end
  end

endmodule

[src/lir_interp.sv]
`timescale 1ns / 1ps

module lir_interp
  import lir_pkg::*;
#(
  parameter int CHANNEL_SLOTS = 8,
  parameter int FRACTION_BITS = 24,
  localparam int CH_W = (CHANNEL_SLOTS > 1) ? $clog2(CHANNEL_SLOTS) : 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  lir_issue_t               issue,
  input  logic [FRACTION_BITS-1:0] issue_frac,
  input  logic [CH_W-1:0]          issue_chan,
  input  logic [31:0]              issue_sample,
  input  logic [31:0]              rd_data,
  output logic                     ready,
  output logic                     out_valid,
  input  logic                     out_stall,
  output out_word_t                out_data
);

  localparam int PW = 34 + FRACTION_BITS;
  localparam int TW = PW + 1;
  localparam logic [TW-1:0] HALF = TW'(1) << (FRACTION_BITS - 1);

  // stage 1: memory read data arrives
  logic                     v1;
  logic signed [31:0]       b1;
  logic [FRACTION_BITS-1:0] f1;
  logic [CH_W-1:0]          c1;
  logic                     byp1;
  logic                     pv1;

  // stage 2: product registered
  logic                     v2;
  logic signed [31:0]       a2;
  logic signed [31:0]       b2;
  logic signed [PW-1:0]     p2;
  logic [CH_W-1:0]          c2;
  logic                     byp2;

  logic                     r1, r2, r3;
  logic signed [31:0]       a1;
  logic signed [32:0]       diff1;
  logic signed [PW-1:0]     prod1;
  logic signed [TW-1:0]     total2;
  logic [TW-1:0]            rnd2;
  logic [31:0]              ch_wide;

  assign r3    = !out_valid || !out_stall;
  assign r2    = !v2 || r3;
  assign r1    = !v1 || r2;
  assign ready = r1;

  always_comb begin
    a1      = pv1 ? $signed(rd_data) : 32'sd0;
    diff1   = {b1[31], b1} - {a1[31], a1};
    prod1   = diff1 * $signed({1'b0, f1});
    total2  = ($signed(TW'(a2)) <<< FRACTION_BITS) + TW'(p2);
    // half away from zero: negative totals round with half minus one
    rnd2    = TW'(total2) + HALF - TW'(total2[TW-1]);
    ch_wide = 32'(c2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (r1) begin
        v1 <= issue.fire;
      end
      if (r2) begin
        v2 <= v1;
      end
      if (r3) begin
        out_valid <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (r1 && issue.fire) begin
      b1   <= issue_sample;
      f1   <= issue_frac;
      c1   <= issue_chan;
      byp1 <= issue.bypass;
      pv1  <= issue.prev_valid;
    end
    if (r2 && v1) begin
      a2   <= a1;
      b2   <= b1;
      p2   <= prod1;
      c2   <= c1;
      byp2 <= byp1;
    end
    if (r3 && v2) begin
      out_data.out_sample  <= byp2 ? b2 : rnd2[FRACTION_BITS+31:FRACTION_BITS];
      out_data.out_channel <= ch_wide[2:0];
    end
  end

endmodule

[src/linear_interp_resampler.sv]
`timescale 1ns / 1ps

// Linear interpolation resampler for interleaved multichannel samples.
// Input words carry one sample of the current channel, channels in order
// 0 .. count-1 per frame; start_of_stream restarts the phase. Each output
// word carries one interpolated sample and its channel. Output positions
// advance by step_ratio (unsigned, FRACTION_BITS fraction bits, >= 1.0);
// an output is produced while frame floor(pos)+1 arrives, so each input
// word yields zero or one output word.
// Throughput: one input word per cycle while the output is not stalled,
// set by the previous-frame memory (each accepted word writes its entry,
// which a word producing an output reads in the accept cycle). An output
// word passes memory read, multiply, round and output register stages. A
// stalled output holds; the pipeline keeps accepting until its three
// stages are full, then in_stall rises. Reset clears the phase, channel
// position and the valid marks of the stored frame (which reads as zero),
// sets step_ratio to 1.0 and channel_count to 1. The user must write the
// configuration (cfg_write/cfg_index/cfg_data) only when idle; unchecked.
module linear_interp_resampler
  import lir_pkg::*;
#(
  parameter int CHANNEL_SLOTS = 8,
  parameter int FRACTION_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_data,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int CH_W = (CHANNEL_SLOTS > 1) ? $clog2(CHANNEL_SLOTS) : 1;

  logic [31:0]              step_ratio;
  logic [3:0]               channel_count;
  logic                     ready;
  logic                     accept;
  lir_issue_t               issue;
  logic [FRACTION_BITS-1:0] issue_frac;
  logic [CH_W-1:0]          issue_chan;
  logic [31:0]              issue_sample;
  logic [31:0]              rd_data;

  assign in_stall = !ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_ratio    <= 32'(1) << FRACTION_BITS;
      channel_count <= 4'd1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_STEP_RATIO:    step_ratio    <= cfg_data;
        REG_CHANNEL_COUNT: channel_count <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  lir_ctrl #(
    .CHANNEL_SLOTS (CHANNEL_SLOTS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_data       (in_data),
    .ready         (ready),
    .step_ratio    (step_ratio),
    .channel_count (channel_count),
    .accept        (accept),
    .issue         (issue),
    .issue_frac    (issue_frac),
    .issue_chan    (issue_chan),
    .issue_sample  (issue_sample)
  );

  lir_ram #(
    .WIDTH (32),
    .DEPTH (CHANNEL_SLOTS)
  ) u_prev_ram (
    .clk   (clk),
    .we    (accept),
    .waddr (issue_chan),
    .wdata (issue_sample),
    .re    (issue.fire),
    .raddr (issue_chan),
    .rdata (rd_data)
  );

  lir_interp #(
    .CHANNEL_SLOTS (CHANNEL_SLOTS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_interp (
    .clk          (clk),
    .rst          (rst),
    .issue        (issue),
    .issue_frac   (issue_frac),
    .issue_chan   (issue_chan),
    .issue_sample (issue_sample),
    .rd_data      (rd_data),
    .ready        (ready),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data)
  );

  // frame 0 always passes its sample through as an output
  a_bypass_fires: assert property (@(posedge clk) disable iff (rst)
    issue.bypass |-> issue.fire)
    else $error("bypass word without output");

  // an unstalled output never backs up into the input
  a_no_stall_free: assert property (@(posedge clk) disable iff (rst)
    !out_stall |-> !in_stall)
    else $error("input stalled while output drains");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // only words that produce an output read the memory, and they are accepted
  a_fire_accept: assert property (@(posedge clk) disable iff (rst)
    issue.fire |-> (in_valid && !in_stall))
    else $error("output issued without accepted word");

endmodule
